// File: hdl/pot_pkg.sv
// Shared types and constants for the perceptron online trainer.
// Used by pot_cell and perceptron_online_trainer_core; no dependencies.
package pot_pkg;

   // Fixed field widths
   localparam int W_W       = 32;            // weight / prediction, Q16.16
   localparam int X_W       = 8;             // one sample
   localparam int RATE_BITS = 16;            // learning rate fraction bits
   localparam int PROD_W    = W_W + X_W;     // weight * sample
   localparam int ERR_W     = W_W + 1;       // target - prediction
   localparam int SCL_W     = 50;            // rate * error, signed
   localparam int STP_W     = SCL_W + X_W;   // rate * error * sample
   localparam int RSP_W     = 40;            // result tdata width

   localparam logic signed [W_W-1:0] W_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [W_W-1:0] W_MIN = 32'sh8000_0000;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEARNING_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRE_THRESHOLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_ONE       = 2'd3;

   localparam logic [15:0] RATE_RESET = 16'd6554;
   localparam logic [16:0] NEAR_RESET = 17'd65535;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DECIDE,
      ST_SCALE,
      ST_STEP,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Strobes from the sequencer to every cell
   typedef struct packed {
      logic load;   // latch the sample
      logic mul;    // weight * sample
      logic acc;    // add product to the running sum from the left neighbor
      logic step;   // scaled error * sample
      logic upd;    // write the saturated new weight
   } cell_ctrl_type;

endpackage

// File: hdl/pot_cell.sv
// One cell of the trainer chain: holds one weight and its sample, adds its
// product to the partial sum from its left neighbor. Depends on pot_pkg.
module pot_cell #(
   parameter int SUM_W = 42
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pot_pkg::cell_ctrl_type              ctrl,
   input  logic signed [pot_pkg::X_W-1:0]      x_in,
   input  logic signed [SUM_W-1:0]             psum_in,
   input  logic signed [pot_pkg::SCL_W-1:0]    scaled,
   output logic signed [SUM_W-1:0]             psum_out
);

   localparam int XW  = pot_pkg::X_W;
   localparam int WW  = pot_pkg::W_W;
   localparam int PW  = pot_pkg::PROD_W;
   localparam int STW = pot_pkg::STP_W;
   localparam int SHW = STW - pot_pkg::RATE_BITS;
   localparam int AW  = SHW + 1;

   logic signed [XW-1:0]    x_ff;
   logic signed [WW-1:0]    w_ff;
   logic signed [WW-1:0]    w_in;
   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    prod_in;
   logic signed [SUM_W-1:0] psum_ff;
   logic signed [SUM_W-1:0] psum_in_v;
   logic signed [STW-1:0]   stp_ff;
   logic signed [STW-1:0]   stp_in;
   logic signed [SHW-1:0]   shifted;
   logic signed [AW-1:0]    upd_sum;

   // Forward product and running sum
   assign prod_in   = w_ff * x_ff;
   assign psum_in_v = psum_in + SUM_W'(prod_ff);
   assign psum_out  = psum_ff;

   // Update step: floor((rate*err*x) / 2^16) is dropping the low bits
   assign stp_in  = scaled * x_ff;
   assign shifted = $signed(stp_ff[STW-1:pot_pkg::RATE_BITS]);
   assign upd_sum = AW'(w_ff) + AW'(shifted);

   // Saturate the new weight to 32 bits
   always_comb begin
      if (upd_sum > AW'(pot_pkg::W_MAX)) begin
         w_in = pot_pkg::W_MAX;
      end else if (upd_sum < AW'(pot_pkg::W_MIN)) begin
         w_in = pot_pkg::W_MIN;
      end else begin
         w_in = WW'(upd_sum);
      end
   end

   // Weight register
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else if (ctrl.upd) begin
         w_ff <= w_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff <= x_in;
      end
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc) begin
         psum_ff <= psum_in_v;
      end
      if (ctrl.step) begin
         stp_ff <= stp_in;
      end
   end

endmodule

// File: hdl/perceptron_online_trainer_core.sv
// Perceptron online trainer, top level: sequencer, activation and error
// scaling around a chain of pot_cell. Depends on pot_pkg and pot_cell.
//
// Usage:
//   req_* carries one training item: four signed 8-bit samples and the
//   target sign in tdata, the end-of-epoch mark in tlast. rsp_* returns one
//   result per item: the prediction made before the update, the correct
//   flag and, at epoch end, whether the whole epoch was correct.
//   csr_* writes the mode, learning rate, threshold and near-one registers;
//   write them only while no item is in flight.
// Operation:
//   The block works on one item at a time. An accepted item runs through
//   the states MUL, ACC (once per cell), DECIDE, SCALE, STEP, UPDATE and
//   DONE; the next item is taken only back in IDLE. The partial sum walks
//   the cell chain one cell per cycle, and the update runs through two
//   registered multiplies before the weights are written back.
//   The result sits in an output register; a new item is taken while it
//   waits. If the receiver still stalls when the next result is ready, the
//   sequencer holds that result until the register frees.
// Reset clears the weights to zero, the epoch flag to one and loads the
// register defaults (threshold mode, rate about 0.1, near-one 65535).
module perceptron_online_trainer_core #(
   parameter  int NUM_INPUTS = 4,
   parameter  int FRAC_BITS  = 16,
   localparam int REQ_W      = ((NUM_INPUTS * 8 + 1 + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample_a, sample_b, ... (8 bits each), target_positive, zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,
   input  logic                              req_tlast,
   // prediction[31:0], correct, epoch_clean, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pot_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_we,
   input  logic [pot_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pot_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int XW     = pot_pkg::X_W;
   localparam int WW     = pot_pkg::W_W;
   localparam int EW     = pot_pkg::ERR_W;
   localparam int SW     = pot_pkg::SCL_W;
   localparam int RW     = pot_pkg::RSP_W;
   localparam int SUM_W  = pot_pkg::PROD_W + ((NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 0);
   localparam int CNT_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam logic [CNT_W-1:0]    CNT_LAST = CNT_W'(NUM_INPUTS - 1);
   localparam logic signed [WW-1:0] ONE_W   = WW'(longint'(1) << FRAC_BITS);
   localparam logic signed [EW-1:0] ONE_E   = EW'(longint'(1) << FRAC_BITS);

   // Configuration registers
   logic                 linear_mode_ff;
   logic [15:0]          rate_ff;
   logic signed [WW-1:0] thresh_ff;
   logic [16:0]          near_ff;

   // Sequencer
   pot_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   pot_pkg::cell_ctrl_type ctrl;
   logic                   accept;
   logic                   out_load;

   // Item and decision registers
   logic                 tpos_ff;
   logic                 last_ff;
   logic signed [WW-1:0] pred_ff, pred_in;
   logic                 ok_ff, ok_in;
   logic signed [SW-1:0] scaled_ff, scaled_in;
   logic                 epoch_ok_ff;
   logic                 ok_all;

   // Output register
   logic          rsp_valid_ff;
   logic [RW-1:0] rsp_data_ff;

   // Chain wiring
   logic signed [SUM_W-1:0] psum_chain [NUM_INPUTS+1];
   logic signed [SUM_W-1:0] sum;

   // Activation
   logic                 sum_hi, sum_lo, fire;
   logic signed [WW-1:0] lin_pred;
   logic signed [EW-1:0] pred_e, near_e, err;

   assign accept     = req_tvalid && req_tready;
   assign psum_chain[0] = '0;
   assign sum        = psum_chain[NUM_INPUTS];

   // Cell chain, one weight per cell
   for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_cell
      pot_cell #(
         .SUM_W (SUM_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .x_in     ($signed(req_tdata[i*XW +: XW])),
         .psum_in  (psum_chain[i]),
         .scaled   (scaled_ff),
         .psum_out (psum_chain[i+1])
      );
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         linear_mode_ff <= 1'b0;
         rate_ff        <= pot_pkg::RATE_RESET;
         thresh_ff      <= '0;
         near_ff        <= pot_pkg::NEAR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pot_pkg::REG_LINEAR_MODE:    linear_mode_ff <= csr_wdata[0];
            pot_pkg::REG_LEARNING_RATE:  rate_ff        <= csr_wdata[15:0];
            pot_pkg::REG_FIRE_THRESHOLD: thresh_ff      <= $signed(csr_wdata[WW-1:0]);
            pot_pkg::REG_NEAR_ONE:       near_ff        <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Activation and correctness on the exact sum
   always_comb begin
      sum_hi   = sum > SUM_W'(pot_pkg::W_MAX);
      sum_lo   = sum < SUM_W'(pot_pkg::W_MIN);
      lin_pred = sum_hi ? pot_pkg::W_MAX : (sum_lo ? pot_pkg::W_MIN : WW'(sum));
      fire     = sum > SUM_W'(thresh_ff);
      pred_in  = linear_mode_ff ? lin_pred : (fire ? ONE_W : -ONE_W);
      pred_e   = EW'(pred_in);
      near_e   = EW'($signed({1'b0, near_ff}));
      if (linear_mode_ff) begin
         ok_in = tpos_ff ? (pred_e >= near_e) : (pred_e <= -near_e);
      end else begin
         ok_in = (fire == tpos_ff);
      end
   end

   // Error scaled by the learning rate
   assign err       = (tpos_ff ? ONE_E : -ONE_E) - EW'(pred_ff);
   assign scaled_in = $signed({1'b0, rate_ff}) * err;

   assign ok_all = epoch_ok_ff && ok_ff;

   // Sequencer: next state and strobes
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ctrl       = '0;
      out_load   = 1'b0;
      req_tready = (state_ff == pot_pkg::ST_IDLE);
      case (state_ff)
         pot_pkg::ST_IDLE: begin
            if (accept) begin
               ctrl.load = 1'b1;
               state_in  = pot_pkg::ST_MUL;
            end
         end
         pot_pkg::ST_MUL: begin
            ctrl.mul = 1'b1;
            cnt_in   = '0;
            state_in = pot_pkg::ST_ACC;
         end
         pot_pkg::ST_ACC: begin
            ctrl.acc = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = pot_pkg::ST_DECIDE;
            end
         end
         pot_pkg::ST_DECIDE: begin
            state_in = pot_pkg::ST_SCALE;
         end
         pot_pkg::ST_SCALE: begin
            state_in = pot_pkg::ST_STEP;
         end
         pot_pkg::ST_STEP: begin
            ctrl.step = 1'b1;
            state_in  = pot_pkg::ST_UPDATE;
         end
         pot_pkg::ST_UPDATE: begin
            ctrl.upd = 1'b1;
            state_in = pot_pkg::ST_DONE;
         end
         pot_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = pot_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pot_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pot_pkg::ST_IDLE;
         cnt_ff       <= '0;
         epoch_ok_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (out_load) begin
            epoch_ok_ff  <= last_ff ? 1'b1 : ok_all;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item payload, decision and result registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         tpos_ff <= req_tdata[NUM_INPUTS*XW];
         last_ff <= req_tlast;
      end
      if (state_ff == pot_pkg::ST_DECIDE) begin
         pred_ff <= pred_in;
         ok_ff   <= ok_in;
      end
      if (state_ff == pot_pkg::ST_SCALE) begin
         scaled_ff <= scaled_in;
      end
      if (out_load) begin
         rsp_data_ff <= {{(RW - WW - 2){1'b0}}, last_ff && ok_all, ok_ff, pred_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: test/testbench.sv
// Self-checking bench for perceptron_online_trainer_core: trains the neuron on random
// epochs under several register settings and checks every result against a local model.
// Depends on pot_pkg and perceptron_online_trainer_core.
`timescale 1ns / 1ps

module testbench;

   localparam int      REQ_BITS = 40;
   localparam int      LIMIT    = 600000;   // cycles before the run is declared hung
   localparam int      DRAIN    = 12;       // wait after the queues empty, before new register writes
   localparam int      HOLD_AT  = 400;      // results taken before the long receiver hold
   localparam int      HOLD_LEN = 300;
   localparam longint  ONE_Q    = 64'sd1 <<< 16;

   typedef struct packed {
      logic            last;
      logic            tpos;
      logic [3:0][7:0] smp;   // smp[0] is sample_a
   } train_item_type;

   typedef struct packed {
      logic signed [31:0] prediction;
      logic               correct;
      logic               epoch_clean;
   } result_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [REQ_BITS-1:0]            req_tdata  = '0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [pot_pkg::RSP_W-1:0]      rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [pot_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [pot_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   perceptron_online_trainer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Model state: registers and trained weights
   logic               mode_linear = 1'b0;
   logic [15:0]        rate_q16    = pot_pkg::RATE_RESET;
   logic signed [31:0] fire_thr    = '0;
   logic [16:0]        near_one_q  = pot_pkg::NEAR_RESET;
   logic signed [31:0] weight_q [4] = '{default: '0};
   logic               epoch_ok    = 1'b1;

   train_item_type training_items [$];
   result_type     expected_results [$];
   train_item_type offered;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;
   int mismatch_count = 0;
   int results_checked = 0;
   int clean_epochs  = 0;
   int weight_sats   = 0;
   int settings_run  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint sat32(longint v);
      if (v > longint'(pot_pkg::W_MAX)) return longint'(pot_pkg::W_MAX);
      if (v < longint'(pot_pkg::W_MIN)) return longint'(pot_pkg::W_MIN);
      return v;
   endfunction

   // One training step: prediction from current weights, then the weight update
   function automatic result_type perceptron_train(train_item_type it);
      longint     acc, pred, target, err, scaled, step, nxt, w_l, x, near_l, rate_l, thr_l;
      logic       ok;
      result_type r;
      acc    = 0;
      near_l = longint'(near_one_q);
      rate_l = longint'(rate_q16);
      thr_l  = longint'(fire_thr);
      for (int i = 0; i < 4; i++) begin
         w_l = longint'(weight_q[i]);
         x   = longint'($signed(it.smp[i]));
         acc += w_l * x;
      end
      target = it.tpos ? ONE_Q : -ONE_Q;
      if (mode_linear) begin
         pred = sat32(acc);
         ok   = it.tpos ? (pred >= near_l) : (pred <= -near_l);
      end else begin
         pred = (acc > thr_l) ? ONE_Q : -ONE_Q;
         ok   = (pred == target);
      end
      // delta update, truncated toward minus infinity, saturating weights
      err    = target - pred;
      scaled = rate_l * err;
      for (int i = 0; i < 4; i++) begin
         w_l  = longint'(weight_q[i]);
         x    = longint'($signed(it.smp[i]));
         step = (scaled * x) >>> pot_pkg::RATE_BITS;
         nxt  = sat32(w_l + step);
         if (nxt != w_l + step) weight_sats++;
         weight_q[i] = nxt[31:0];
      end
      epoch_ok      = epoch_ok && ok;
      r.prediction  = pred[31:0];
      r.correct     = ok;
      r.epoch_clean = 1'b0;
      if (it.last) begin
         r.epoch_clean = epoch_ok;
         epoch_ok      = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Driver: offers items from the queue, predicts each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(perceptron_train(offered));
         if (!req_tvalid || req_tready) begin
            if (training_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = training_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'b0, offered.tpos, offered.smp};
               req_tlast  <= offered.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold-off to back the block up
   int  taken_count = 0;
   int  hold_left   = 0;
   logic hold_done  = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) taken_count <= taken_count + 1;
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && taken_count == HOLD_AT) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Monitor: each taken result against the oldest expectation
   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with none expected, tdata %h", rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (want.epoch_clean) clean_epochs++;
            if (rsp_tdata[31:0] !== want.prediction)
               report_mismatch($sformatf("prediction got %h want %h",
                                         rsp_tdata[31:0], want.prediction));
            if (rsp_tdata[32] !== want.correct)
               report_mismatch($sformatf("correct got %b want %b",
                                         rsp_tdata[32], want.correct));
            if (rsp_tdata[33] !== want.epoch_clean)
               report_mismatch($sformatf("epoch_clean got %b want %b",
                                         rsp_tdata[33], want.epoch_clean));
         end
      end
   end

   // Cycle counter and hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic wait_idle();
      while (training_items.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(logic [pot_pkg::CSR_IDX_W-1:0] idx,
                            logic [pot_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         pot_pkg::REG_LINEAR_MODE:    mode_linear = val[0];
         pot_pkg::REG_LEARNING_RATE:  rate_q16    = val[15:0];
         pot_pkg::REG_FIRE_THRESHOLD: fire_thr    = val;
         pot_pkg::REG_NEAR_ONE:       near_one_q  = val[16:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic lin, logic [15:0] rate, logic [31:0] thr, logic [16:0] near);
      wait_idle();
      write_reg(pot_pkg::REG_LINEAR_MODE, {31'b0, lin});
      write_reg(pot_pkg::REG_LEARNING_RATE, {16'b0, rate});
      write_reg(pot_pkg::REG_FIRE_THRESHOLD, thr);
      write_reg(pot_pkg::REG_NEAR_ONE, {15'b0, near});
      settings_run++;
   endtask

   task automatic push_item(int a, int b, int c, int d, logic tpos, logic last);
      train_item_type it;
      it.smp[0] = a[7:0];
      it.smp[1] = b[7:0];
      it.smp[2] = c[7:0];
      it.smp[3] = d[7:0];
      it.tpos   = tpos;
      it.last   = last;
      training_items.push_back(it);
   endtask

   function automatic int rand_sample(int amp);
      if (amp != 0 && $urandom_range(9) != 0) return $urandom_range(2 * amp) - amp;
      if ($urandom_range(99) < 40) return $urandom_range(6) - 3;
      return $urandom_range(255) - 128;
   endfunction

   // Random epochs of 1..8 items; targets mostly follow a fixed linear rule
   // so the neuron can converge, the rest are noise
   task automatic random_epochs(int n_items, int amp);
      int s [4];
      int len, made;
      logic tpos;
      made = 0;
      while (made < n_items) begin
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            for (int i = 0; i < 4; i++) s[i] = rand_sample(amp);
            if ($urandom_range(99) < 85) tpos = (3 * s[0] - 2 * s[1] + s[2] - s[3]) > 0;
            else tpos = 1'($urandom_range(1));
            push_item(s[0], s[1], s[2], s[3], tpos, k == len - 1);
         end
         made += len;
      end
   endtask

   task automatic random_phase(logic lin, logic [15:0] rate, logic [31:0] thr,
                               logic [16:0] near, int amp, int spct, int rpct);
      configure(lin, rate, thr, near);
      send_idle_pct = spct;
      recv_idle_pct = rpct;
      random_epochs(200, amp);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 62;

      // Threshold mode, default rate: extremes, single-item and zero-sample epochs
      configure(1'b0, pot_pkg::RATE_RESET, 32'd0, pot_pkg::NEAR_RESET);
      push_item(0, 0, 0, 0, 1'b1, 1'b0);
      push_item(127, 127, 127, 127, 1'b1, 1'b0);
      push_item(-128, -128, -128, -128, 1'b0, 1'b1);
      push_item(127, -128, 127, -128, 1'b0, 1'b0);
      push_item(-128, 127, -128, 127, 1'b1, 1'b1);
      push_item(1, -1, 0, 0, 1'b1, 1'b1);
      push_item(0, 0, 0, 0, 1'b0, 1'b1);
      push_item(-1, -1, -1, -1, 1'b0, 1'b0);
      push_item(1, 1, 1, 1, 1'b1, 1'b1);

      // Linear mode at full rate: sum and weight saturation, near_one at 1.0
      configure(1'b1, 16'hFFFF, 32'd0, 17'd65536);
      repeat (4) push_item(127, 127, 127, 127, 1'b1, 1'b0);
      repeat (3) push_item(-128, -128, -128, -128, 1'b0, 1'b0);
      push_item(127, -128, 127, -128, 1'b1, 1'b1);
      push_item(0, 0, 0, 0, 1'b1, 1'b1);
      push_item(-128, 127, 0, 0, 1'b0, 1'b1);

      // Random phases; idle pattern changes over the run
      random_phase(1'b0, pot_pkg::RATE_RESET, 32'd0, pot_pkg::NEAR_RESET, 0, 37, 62);
      random_phase(1'b0, 16'hFFFF, 32'h8000_0000, 17'd0, 0, 37, 62);
      random_phase(1'b0, 16'd0, 32'h7FFF_FFFF, 17'd65536, 0, 37, 62);
      random_phase(1'b1, pot_pkg::RATE_RESET, 32'd0, pot_pkg::NEAR_RESET, 1, 37, 62);
      random_phase(1'b1, 16'd1, 32'd0, 17'd0, 2, 62, 37);
      random_phase(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 17'd65536, 0, 62, 37);
      random_phase(1'($urandom_range(1)), 16'($urandom_range(65535)), $urandom,
                   17'($urandom_range(65536)), 0, 62, 37);
      random_phase(1'b1, 16'($urandom_range(8000)), $urandom,
                   17'($urandom_range(65536)), 1, 0, 0);
      random_phase(1'($urandom_range(1)), 16'($urandom_range(65535)), $urandom,
                   17'($urandom_range(65536)), 0, 0, 0);
      random_phase(1'b0, pot_pkg::RATE_RESET, $urandom_range(200000) - 100000,
                   pot_pkg::NEAR_RESET, 0, 0, 0);

      wait_idle();
      $display("Checked %0d results over %0d register settings in both activation modes;",
               results_checked, settings_run);
      $display("%0d clean epochs, %0d saturated weight updates.", clean_epochs, weight_sats);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
